>>> hw/rtl/dod_pkg.sv
package dod_pkg;

	// Series length and output fraction width.
	localparam int APPROX_STEPS = 16;
	localparam int SAMPLE_WIDTH = 16;
	localparam int FRAC_BITS    = (SAMPLE_WIDTH > 30) ? 30 : SAMPLE_WIDTH;
	localparam int FRAC_SHIFT   = 30 - FRAC_BITS;
	localparam int FW           = FRAC_BITS + 1;

	// Port and product widths.
	localparam int TIME_W = 20;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 2;
	localparam int PROD_W = CFG_W + TIME_W;

	// Series datapath: operand is Q2.30 up to about 2.47, accumulator is 0..1 in Q2.30.
	localparam int ARG_W   = 32;
	localparam int ACC_W   = 31;
	localparam int RECIP_W = ARG_W + 1;
	localparam int DIV_W   = $clog2(2 * APPROX_STEPS * (2 * APPROX_STEPS - 1) + 1);
	localparam logic [ACC_W-1:0] ONE_Q30 = ACC_W'(1) << 30;

	// Phase reduction.
	localparam int PHASE_SHIFT = 27;
	localparam int PH_W        = PROD_W + PHASE_SHIFT;
	localparam int ANG_W       = 48;
	localparam int MOD_STEPS   = PH_W - ANG_W + 1;
	localparam logic [ANG_W-1:0] TWO_PI_Q  = 48'hC90FDAA22169;
	localparam logic [ANG_W-1:0] PI_Q      = TWO_PI_Q >> 1;
	localparam logic [ANG_W-1:0] HALF_PI_Q = TWO_PI_Q >> 2;
	localparam int R30_SHIFT = 15;

	// The exponential argument x = decay * t must stay below 16 << 20.
	localparam int EXP_LIMIT_BIT = 24;

	// Latencies.
	localparam int STEP_LAT   = 4;
	localparam int SERIES_LAT = STEP_LAT * APPROX_STEPS;
	localparam int PHASE_LAT  = MOD_STEPS + 4;
	localparam int SQ_STEPS   = 4;
	localparam int TOTAL_LAT  = 1 + PHASE_LAT + SERIES_LAT + SQ_STEPS + 3;

	localparam logic [ACC_W:0] ROUND_FRAC = ((ACC_W + 1)'(1) << FRAC_SHIFT) >> 1;
	localparam int FRAC_HALF = 1 << (FRAC_BITS - 1);

	typedef enum logic [IDX_W-1:0] {
		REG_AMPLITUDE = 2'd0,
		REG_DECAY     = 2'd1,
		REG_OMEGA     = 2'd2
	} dod_reg_t;

	typedef struct packed {
		logic neg;
		logic zero;
	} dod_flags_t;

	// Round a Q2.30 value half up to FRAC_BITS fraction bits.
	function automatic logic [FW-1:0] to_frac(input logic [ACC_W-1:0] v);
		logic [ACC_W:0] s;
		s = {1'b0, v} + ROUND_FRAC;
		return FW'(s >> FRAC_SHIFT);
	endfunction

endpackage

>>> hw/rtl/dod_series_step.sv
// One Horner step: acc_out = max(0, 1 - floor(floor(arg * acc_in / 2^30) / divisor)).
// The division uses a reciprocal estimate that is low by at most one, then a correction.
module dod_series_step (
	input  logic                           clk,
	input  logic                           en,
	input  logic [dod_pkg::ARG_W-1:0]      arg_in,
	input  logic [dod_pkg::ACC_W-1:0]      acc_in,
	input  logic [dod_pkg::DIV_W-1:0]      divisor,
	input  logic [dod_pkg::RECIP_W-1:0]    recip,
	output logic [dod_pkg::ARG_W-1:0]      arg_out,
	output logic [dod_pkg::ACC_W-1:0]      acc_out
);

	localparam int AW = dod_pkg::ARG_W;
	localparam int CW = dod_pkg::ACC_W;
	localparam int P1_W = AW + CW;
	localparam int P2_W = AW + dod_pkg::RECIP_W;
	localparam int P3_W = AW + dod_pkg::DIV_W;

	logic [P1_W-1:0] prod1;
	logic [P2_W-1:0] prod2;
	logic [P3_W-1:0] prod3;
	logic [AW-1:0]   quot;

	logic [AW-1:0] arg_s1, arg_s2, arg_s3, arg_s4;
	logic [AW-1:0] n_s1, n_s2;
	logic [AW-1:0] q0_s2, q0_s3;
	logic [AW-1:0] r_s3;
	logic [CW-1:0] acc_s4;

	always_comb begin
		prod1 = P1_W'(arg_in) * P1_W'(acc_in);
		prod2 = P2_W'(n_s1) * P2_W'(recip);
		prod3 = P3_W'(q0_s2) * P3_W'(divisor);
		quot  = q0_s3 + ((r_s3 >= AW'(divisor)) ? AW'(1) : AW'(0));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			arg_s1 <= arg_in;
			n_s1   <= prod1[AW+29:30];
			arg_s2 <= arg_s1;
			n_s2   <= n_s1;
			q0_s2  <= prod2[AW+AW-1:AW];
			arg_s3 <= arg_s2;
			q0_s3  <= q0_s2;
			r_s3   <= n_s2 - prod3[AW-1:0];
			arg_s4 <= arg_s3;
			acc_s4 <= (quot >= AW'(dod_pkg::ONE_Q30)) ? '0 : CW'(AW'(dod_pkg::ONE_Q30) - quot);
		end
	end

	assign arg_out = arg_s4;
	assign acc_out = acc_s4;

endmodule

>>> hw/rtl/dod_series.sv
// Alternating Taylor series in Horner form, one pipelined step unit per term.
// With is_cos low the terms divide by k (exponential), otherwise by 2k(2k-1) (cosine).
module dod_series (
	input  logic                      clk,
	input  logic                      en,
	input  logic                      is_cos,
	input  logic [dod_pkg::ARG_W-1:0] arg_in,
	output logic [dod_pkg::ACC_W-1:0] acc_out
);

	localparam int N = dod_pkg::APPROX_STEPS;

	logic [dod_pkg::ARG_W-1:0] arg_c [N];
	logic [dod_pkg::ACC_W-1:0] acc_c [N];

	for (genvar i = 0; i < N; i++) begin : g_step
		localparam int K     = N - i;
		localparam int DIV_E = K;
		localparam int DIV_C = 2 * K * (2 * K - 1);
		localparam logic [dod_pkg::RECIP_W-1:0] REC_E =
			dod_pkg::RECIP_W'((64'd1 << dod_pkg::ARG_W) / DIV_E);
		localparam logic [dod_pkg::RECIP_W-1:0] REC_C =
			dod_pkg::RECIP_W'((64'd1 << dod_pkg::ARG_W) / DIV_C);

		logic [dod_pkg::DIV_W-1:0]   divisor;
		logic [dod_pkg::RECIP_W-1:0] recip;
		logic [dod_pkg::ARG_W-1:0]   a_in;
		logic [dod_pkg::ACC_W-1:0]   c_in;

		assign divisor = is_cos ? dod_pkg::DIV_W'(DIV_C) : dod_pkg::DIV_W'(DIV_E);
		assign recip   = is_cos ? REC_C : REC_E;

		if (i == 0) begin : g_first
			assign a_in = arg_in;
			assign c_in = dod_pkg::ONE_Q30;
		end else begin : g_next
			assign a_in = arg_c[i-1];
			assign c_in = acc_c[i-1];
		end

		dod_series_step u_step (
			.clk     (clk),
			.en      (en),
			.arg_in  (a_in),
			.acc_in  (c_in),
			.divisor (divisor),
			.recip   (recip),
			.arg_out (arg_c[i]),
			.acc_out (acc_c[i])
		);
	end

	assign acc_out = acc_c[N-1];

endmodule

>>> hw/rtl/dod_phase_reduce.sv
// Reduces omega*t (shifted to units of 2^-45 rad) modulo 2*pi, folds it into
// [0, pi/2] and squares the rounded Q2.30 angle for the cosine series.
module dod_phase_reduce (
	input  logic                       clk,
	input  logic                       en,
	input  logic [dod_pkg::PROD_W-1:0] angle_prod,
	output logic [dod_pkg::ARG_W-1:0]  r2,
	output logic                       neg
);

	localparam int PW = dod_pkg::PH_W;
	localparam int GW = dod_pkg::ANG_W;
	localparam int CW = dod_pkg::ACC_W;
	localparam int SQ_W = 2 * CW;
	localparam logic [GW:0] R30_ROUND = (GW + 1)'(1) << (dod_pkg::R30_SHIFT - 1);
	localparam logic [SQ_W-1:0] SQ_ROUND = SQ_W'(1) << 29;

	logic [PW-1:0] mod_in;
	logic [PW-1:0] rem_s [dod_pkg::MOD_STEPS];

	logic [GW-1:0] ph;
	logic [GW-1:0] ph_s1, ph_s2;
	logic          neg_s2, neg_s3, neg_s4;
	logic [CW-1:0] r30_s3;
	logic [dod_pkg::ARG_W-1:0] r2_s4;
	logic [GW:0]   r30_sum;
	logic [SQ_W-1:0] sq;

	assign mod_in = {angle_prod, {dod_pkg::PHASE_SHIFT{1'b0}}};

	// Restoring reduction: one conditional subtract of 2*pi << (MOD_STEPS-1-j) per stage.
	for (genvar j = 0; j < dod_pkg::MOD_STEPS; j++) begin : g_mod
		localparam int SH = dod_pkg::MOD_STEPS - 1 - j;
		localparam logic [PW-1:0] SUB = PW'(dod_pkg::TWO_PI_Q) << SH;
		logic [PW-1:0] src;
		if (j == 0) begin : g_first
			assign src = mod_in;
		end else begin : g_next
			assign src = rem_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= (src >= SUB) ? src - SUB : src;
			end
		end
	end

	always_comb begin
		ph      = rem_s[dod_pkg::MOD_STEPS-1][GW-1:0];
		r30_sum = {1'b0, ph_s2} + R30_ROUND;
		sq      = SQ_W'(r30_s3) * SQ_W'(r30_s3) + SQ_ROUND;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s1 <= (ph >= dod_pkg::PI_Q) ? dod_pkg::TWO_PI_Q - ph : ph;
			if (ph_s1 > dod_pkg::HALF_PI_Q) begin
				neg_s2 <= 1'b1;
				ph_s2  <= (ph_s1 <= dod_pkg::PI_Q) ? dod_pkg::PI_Q - ph_s1 : '0;
			end else begin
				neg_s2 <= 1'b0;
				ph_s2  <= ph_s1;
			end
			neg_s3 <= neg_s2;
			r30_s3 <= CW'(r30_sum >> dod_pkg::R30_SHIFT);
			neg_s4 <= neg_s3;
			r2_s4  <= sq[dod_pkg::ARG_W+29:30];
		end
	end

	assign r2  = r2_s4;
	assign neg = neg_s4;

endmodule

>>> hw/rtl/damped_oscillator_displacement_core.sv
// Damped sinusoid generator: for each sample_time word t (units of 2^-8 s) the core returns
// one displacement word, amplitude * exp(-decay*t) * cos(omega*t) in signed Q3.12, where
// the three factors come from the configuration registers (index 0 amplitude in Q3.12,
// index 1 decay in 2^-12 per second, index 2 omega in 2^-10 rad/s; index 3 is ignored).
// The core is a fixed-depth pipeline that takes one word per clock while in_stall is low,
// made up of input products, phase reduction modulo 2*pi and folding, two sixteen-term
// series of four stages per term running side by side, four squarings of the
// exponential, and rounding and scaling before the output register. The series make up
// most of the pipeline depth. An output register plus one skid entry sit at the end, so
// a stalled output lets one more result word leave the pipeline before in_stall rises;
// the whole pipeline then holds until the consumer takes a word. When decay*t reaches
// 16 or the amplitude is zero the result is zero. Write the registers only while the
// core is empty, since words in flight read them at several stages.
module damped_oscillator_displacement_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [dod_pkg::TIME_W-1:0] sample_time,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [15:0]         displacement,
	input  logic                       cfg_we,
	input  logic [dod_pkg::IDX_W-1:0]  cfg_index,
	input  logic [dod_pkg::CFG_W-1:0]  cfg_data
);

	localparam int PW  = dod_pkg::PROD_W;
	localparam int AW  = dod_pkg::ARG_W;
	localparam int CW  = dod_pkg::ACC_W;
	localparam int FW  = dod_pkg::FW;
	localparam int KW  = dod_pkg::CFG_W;
	localparam int TL  = dod_pkg::TOTAL_LAT;
	localparam int PL  = dod_pkg::PHASE_LAT;
	localparam int FL  = dod_pkg::SERIES_LAT + dod_pkg::SQ_STEPS;
	localparam int SQN = dod_pkg::SQ_STEPS;
	localparam int MW  = KW + FW;

	// Configuration registers.
	logic [KW-1:0] amp_q, decay_q, omega_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q   <= '0;
			decay_q <= '0;
			omega_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				dod_pkg::REG_AMPLITUDE: amp_q   <= cfg_data;
				dod_pkg::REG_DECAY:     decay_q <= cfg_data;
				dod_pkg::REG_OMEGA:     omega_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline advances together unless the skid entry is occupied.
	logic en;
	logic skid_v_q, out_v_q;
	logic [15:0] skid_data_q, out_data_q;
	logic [TL-1:0] vld_q;

	assign en       = !skid_v_q;
	assign in_stall = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TL-2:0], in_valid};
		end
	end

	// Stage 1: the exponent and phase products.
	logic [PW-1:0] xprod_s1, wprod_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			xprod_s1 <= PW'(decay_q) * PW'(sample_time);
			wprod_s1 <= PW'(omega_q) * PW'(sample_time);
		end
	end

	// exp(-x) is computed as exp(-x/16)^16; x/16 in Q2.30 is x shifted left by six.
	// The exponential argument waits here while the phase is reduced.
	logic          ezero;
	logic [AW-1:0] earg;
	logic [AW-1:0] earg_s2  [PL];
	logic          ezero_s2 [PL];

	assign ezero = (|xprod_s1[PW-1:dod_pkg::EXP_LIMIT_BIT]) || (amp_q == '0);
	assign earg  = AW'({xprod_s1[dod_pkg::EXP_LIMIT_BIT-1:0], 6'b0});

	always_ff @(posedge clk) begin
		if (en) begin
			earg_s2[0]  <= earg;
			ezero_s2[0] <= ezero;
			for (int i = 1; i < PL; i++) begin
				earg_s2[i]  <= earg_s2[i-1];
				ezero_s2[i] <= ezero_s2[i-1];
			end
		end
	end

	logic [AW-1:0] r2;
	logic          pneg;

	dod_phase_reduce u_phase (
		.clk        (clk),
		.en         (en),
		.angle_prod (wprod_s1),
		.r2         (r2),
		.neg        (pneg)
	);

	// Both series run in lockstep.
	logic [CW-1:0] exp_acc, cos_acc;

	dod_series u_exp (
		.clk     (clk),
		.en      (en),
		.is_cos  (1'b0),
		.arg_in  (earg_s2[PL-1]),
		.acc_out (exp_acc)
	);

	dod_series u_cos (
		.clk     (clk),
		.en      (en),
		.is_cos  (1'b1),
		.arg_in  (r2),
		.acc_out (cos_acc)
	);

	// Flags ride alongside the series and the squarings.
	dod_pkg::dod_flags_t flags;
	dod_pkg::dod_flags_t fl_s3 [FL];

	assign flags = '{neg: pneg, zero: ezero_s2[PL-1]};

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s3[0] <= flags;
			for (int i = 1; i < FL; i++) begin
				fl_s3[i] <= fl_s3[i-1];
			end
		end
	end

	// Four squarings, each rounded half up in Q2.30.
	function automatic logic [CW-1:0] sq_q30(input logic [CW-1:0] v);
		logic [2*CW-1:0] p;
		p = (2*CW)'(v) * (2*CW)'(v) + ((2*CW)'(1) << 29);
		return p[CW+29:30];
	endfunction

	logic [CW-1:0] env_s4 [SQN];
	logic [CW-1:0] cos_s4 [SQN];

	always_ff @(posedge clk) begin
		if (en) begin
			env_s4[0] <= sq_q30(exp_acc);
			cos_s4[0] <= cos_acc;
			for (int i = 1; i < SQN; i++) begin
				env_s4[i] <= sq_q30(env_s4[i-1]);
				cos_s4[i] <= cos_s4[i-1];
			end
		end
	end

	// Rounding to the output fraction width, then the two scaling products.
	logic [KW-1:0] mag;
	logic          amp_neg;
	logic [FW-1:0] envf_s5, cosf_s5, cosf_s6;
	dod_pkg::dod_flags_t fl_s5, fl_s6, fl_s7;
	logic [KW-1:0] m1_s6, m2_s7;
	logic [MW-1:0] m1_full, m2_full;
	logic          neg_res;
	logic [15:0]   res;

	always_comb begin
		amp_neg = amp_q[KW-1];
		mag     = amp_neg ? KW'(~amp_q + KW'(1)) : amp_q;
		m1_full = MW'(mag) * MW'(envf_s5) + MW'(dod_pkg::FRAC_HALF);
		m2_full = MW'(m1_s6) * MW'(cosf_s6) + MW'(dod_pkg::FRAC_HALF);
		neg_res = fl_s7.neg ^ amp_neg;
		// A positive full-scale product saturates; the negative one is representable.
		if (fl_s7.zero) begin
			res = '0;
		end else if (neg_res) begin
			res = 16'(~m2_s7 + KW'(1));
		end else if (m2_s7[KW-1]) begin
			res = 16'h7FFF;
		end else begin
			res = m2_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			envf_s5 <= dod_pkg::to_frac(env_s4[SQN-1]);
			cosf_s5 <= dod_pkg::to_frac(cos_s4[SQN-1]);
			fl_s5   <= fl_s3[FL-1];
			m1_s6   <= m1_full[dod_pkg::FRAC_BITS+KW-1:dod_pkg::FRAC_BITS];
			cosf_s6 <= cosf_s5;
			fl_s6   <= fl_s5;
			m2_s7   <= m2_full[dod_pkg::FRAC_BITS+KW-1:dod_pkg::FRAC_BITS];
			fl_s7   <= fl_s6;
		end
	end

	// Output register with one skid entry behind it.
	logic pop, last_v;

	assign pop    = out_v_q && !out_stall;
	assign last_v = vld_q[TL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || pop) begin
			out_v_q <= last_v;
		end else if (last_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
			end
		end else if (!out_v_q || pop) begin
			out_data_q <= res;
		end else begin
			skid_data_q <= res;
		end
	end

	assign out_valid    = out_v_q;
	assign displacement = out_data_q;

endmodule

>>> hw/rtl/dod_checker.sv
module dod_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic [dod_pkg::TIME_W-1:0] sample_time,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic signed [15:0]         displacement
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(displacement))
		else $error("output word changed while stalled");

	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with an empty output register");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stall rose without a stalled output word");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(sample_time))
		else $error("input word changed while stalled");

endmodule

bind damped_oscillator_displacement_core dod_checker u_dod_checker (.*);
